>>> hdl/lcfb_pkg.sv
// ----------------------------------------------------------------------------
// lcfb_pkg: shared types and constants of the LED command frame blinker
// Beat formats, the operation handed from the frame parser to the LED
// driver, LED mode codes and frame status codes.
// ----------------------------------------------------------------------------
package lcfb_pkg;

  // Fixed frame layout and character codes.
  localparam int unsigned FRAME_LEN  = 6;
  localparam int unsigned STORE_LEN  = FRAME_LEN - 1;
  localparam int unsigned POS_W      = 3;
  localparam logic [7:0]  CH_HASH    = 8'h23;  // '#'
  localparam logic [7:0]  CH_BANG    = 8'h21;  // '!'
  localparam logic [7:0]  CH_TILDE   = 8'h7E;  // '~'
  localparam logic [7:0]  CH_ONE     = 8'h31;  // '1'
  localparam logic [7:0]  CH_TWO     = 8'h32;  // '2'
  localparam logic [7:0]  CH_ZERO    = 8'h30;  // '0'
  localparam logic [7:0]  CH_NINE    = 8'h39;  // '9'

  // LED numbers from a frame run from 0 to 99.
  localparam int unsigned LED_NUM_W  = 7;
  localparam int unsigned LEVELS_W   = 4;

  // Item kinds.
  localparam logic KIND_BYTE = 1'b0;
  localparam logic KIND_TICK = 1'b1;

  // Per-LED mode.
  typedef enum logic [1:0] {
    MODE_OFF   = 2'd0,
    MODE_ON    = 2'd1,
    MODE_BLINK = 2'd2,
    MODE_DONE  = 2'd3
  } mode_t;

  // Frame status reported with each result.
  typedef enum logic [1:0] {
    STAT_NONE      = 2'd0,
    STAT_APPLIED   = 2'd1,
    STAT_MALFORMED = 2'd2,
    STAT_RANGE     = 2'd3
  } status_t;

  // Input beat.
  typedef struct packed {
    logic       kind;
    logic [7:0] frame_byte;
  } item_t;

  // Output beat.
  typedef struct packed {
    logic [LEVELS_W-1:0] led_levels;
    logic                frame_done;
    logic [1:0]          frame_status;
  } result_t;

  // Classified operation passed from the parser to the driver.
  typedef struct packed {
    logic                 is_tick;
    logic                 frame_done;
    status_t              status;
    logic [LED_NUM_W-1:0] led_num;
    mode_t                mode;
  } op_t;

endpackage

>>> hdl/lcfb_front.sv
// ----------------------------------------------------------------------------
// lcfb_front: frame parser
// Gathers command bytes into six-byte frames and classifies each beat into
// a tick, a plain byte, or a finished frame with its status and command.
// ----------------------------------------------------------------------------
module lcfb_front #(
  parameter int unsigned NUM_LEDS = 4
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           item_valid,
  output logic           item_ready,
  input  lcfb_pkg::item_t item,
  output logic           op_valid,
  input  logic           op_ready,
  output lcfb_pkg::op_t  op
);

  logic [lcfb_pkg::POS_W-1:0] byte_position;
  logic [7:0]                 frame_store [lcfb_pkg::STORE_LEN];
  logic                       accept;
  logic                       is_last;

  // Returns the mode that a mode byte selects.
  function automatic lcfb_pkg::mode_t mode_of(input logic [7:0] c);
    lcfb_pkg::mode_t m;
    if (c == lcfb_pkg::CH_ONE) begin
      m = lcfb_pkg::MODE_ON;
    end else if (c == lcfb_pkg::CH_TWO) begin
      m = lcfb_pkg::MODE_BLINK;
    end else begin
      m = lcfb_pkg::MODE_OFF;
    end
    return m;
  endfunction

  // True for an ASCII decimal digit.
  function automatic logic is_digit(input logic [7:0] c);
    return (c >= lcfb_pkg::CH_ZERO) && (c <= lcfb_pkg::CH_NINE);
  endfunction

  assign item_ready = op_ready;
  assign op_valid   = item_valid;
  assign accept     = item_valid && item_ready;
  assign is_last    = (byte_position == lcfb_pkg::POS_W'(lcfb_pkg::STORE_LEN));

  // Byte counter within the current frame.
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= '0;
    end else if (accept && (item.kind == lcfb_pkg::KIND_BYTE)) begin
      if (is_last) begin
        byte_position <= '0;
      end else begin
        byte_position <= byte_position + 1'b1;
      end
    end
  end

  // Frame bytes zero to four; the last byte is taken straight from the input.
  always_ff @(posedge clk) begin
    if (accept && (item.kind == lcfb_pkg::KIND_BYTE) && !is_last) begin
      frame_store[byte_position] <= item.frame_byte;
    end
  end

  // Frame evaluation and beat classification.
  always_comb begin
    logic [3:0]                     d1;
    logic [3:0]                     d2;
    logic [lcfb_pkg::LED_NUM_W-1:0] num;
    lcfb_pkg::status_t              st;
    lcfb_pkg::mode_t                md;

    d1  = 4'(frame_store[1] - lcfb_pkg::CH_ZERO);
    d2  = 4'(frame_store[2] - lcfb_pkg::CH_ZERO);
    num = '0;
    md  = lcfb_pkg::MODE_OFF;
    st  = lcfb_pkg::STAT_MALFORMED;

    if ((frame_store[0] == lcfb_pkg::CH_HASH) &&
        ((frame_store[4] == lcfb_pkg::CH_BANG) ||
         (item.frame_byte == lcfb_pkg::CH_BANG))) begin
      if (frame_store[2] == lcfb_pkg::CH_TILDE) begin
        // Single-digit LED number, mode in byte three.
        if (is_digit(frame_store[1])) begin
          num = lcfb_pkg::LED_NUM_W'(d1);
          md  = mode_of(frame_store[3]);
          st  = lcfb_pkg::STAT_APPLIED;
        end
      end else if (frame_store[3] == lcfb_pkg::CH_TILDE) begin
        // Two-digit LED number, mode in byte four.
        if (is_digit(frame_store[1]) && is_digit(frame_store[2])) begin
          num = (lcfb_pkg::LED_NUM_W'(d1) << 3) + (lcfb_pkg::LED_NUM_W'(d1) << 1)
                + lcfb_pkg::LED_NUM_W'(d2);
          md  = mode_of(frame_store[4]);
          st  = lcfb_pkg::STAT_APPLIED;
        end
      end
    end

    if ((st == lcfb_pkg::STAT_APPLIED) && (32'(num) >= NUM_LEDS)) begin
      st = lcfb_pkg::STAT_RANGE;
    end

    op.is_tick    = (item.kind == lcfb_pkg::KIND_TICK);
    op.frame_done = (item.kind == lcfb_pkg::KIND_BYTE) && is_last;
    op.status     = op.frame_done ? st : lcfb_pkg::STAT_NONE;
    op.led_num    = num;
    op.mode       = md;
  end

endmodule

>>> hdl/lcfb_queue.sv
// ----------------------------------------------------------------------------
// lcfb_queue: two-entry operation queue
// Decouples the frame parser from the LED driver so that either can stall.
// ----------------------------------------------------------------------------
module lcfb_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push_valid,
  output logic          push_ready,
  input  lcfb_pkg::op_t push_op,
  output logic          pop_valid,
  input  logic          pop_ready,
  output lcfb_pkg::op_t pop_op
);

  lcfb_pkg::op_t entries [2];
  logic          wr_ptr;
  logic          rd_ptr;
  logic [1:0]    count;
  logic          push;
  logic          pop;

  assign push_ready = (count != 2'd2);
  assign pop_valid  = (count != 2'd0);
  assign pop_op     = entries[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_op;
    end
  end

endmodule

>>> hdl/lcfb_back.sv
// ----------------------------------------------------------------------------
// lcfb_back: LED driver
// Applies queued operations to the LED modes and levels and holds each
// result beat in an output register until it is taken.
// ----------------------------------------------------------------------------
module lcfb_back #(
  parameter int unsigned NUM_LEDS = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              op_valid,
  output logic              op_ready,
  input  lcfb_pkg::op_t     op,
  output logic              result_valid,
  input  logic              result_ready,
  output lcfb_pkg::result_t result
);

  localparam int unsigned IDX_W = (NUM_LEDS > 1) ? $clog2(NUM_LEDS) : 1;

  lcfb_pkg::mode_t [NUM_LEDS-1:0] led_mode;
  lcfb_pkg::mode_t [NUM_LEDS-1:0] led_mode_next;
  logic [NUM_LEDS-1:0]            blink_phase;
  logic [NUM_LEDS-1:0]            blink_phase_next;
  logic [NUM_LEDS-1:0]            led_level;
  logic [NUM_LEDS-1:0]            led_level_next;
  logic [lcfb_pkg::LEVELS_W-1:0]  levels_next;
  logic                           pop;
  logic [IDX_W-1:0]               idx;

  assign op_ready = !result_valid || result_ready;
  assign pop      = op_valid && op_ready;
  assign idx      = op.led_num[IDX_W-1:0];

  // Next LED state for the operation being taken.
  always_comb begin
    led_mode_next    = led_mode;
    blink_phase_next = blink_phase;
    led_level_next   = led_level;
    if (pop && op.is_tick) begin
      for (int i = 0; i < NUM_LEDS; i++) begin
        case (led_mode[i])
          lcfb_pkg::MODE_ON: begin
            led_level_next[i] = 1'b1;
            led_mode_next[i]  = lcfb_pkg::MODE_DONE;
          end
          lcfb_pkg::MODE_OFF: begin
            led_level_next[i] = 1'b0;
            led_mode_next[i]  = lcfb_pkg::MODE_DONE;
          end
          lcfb_pkg::MODE_BLINK: begin
            led_level_next[i]   = blink_phase[i];
            blink_phase_next[i] = ~blink_phase[i];
          end
          default: begin
            led_level_next[i] = led_level[i];
          end
        endcase
      end
    end else if (pop && op.frame_done && (op.status == lcfb_pkg::STAT_APPLIED)) begin
      led_mode_next[idx] = op.mode;
    end
  end

  // Visible levels: the first four LEDs, zero where no LED exists.
  for (genvar g = 0; g < lcfb_pkg::LEVELS_W; g++) begin : g_levels
    if (g < NUM_LEDS) begin : g_led
      assign levels_next[g] = led_level_next[g];
    end else begin : g_none
      assign levels_next[g] = 1'b0;
    end
  end

  // LED state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      led_mode    <= '{default: lcfb_pkg::MODE_OFF};
      blink_phase <= '0;
      led_level   <= '0;
    end else begin
      led_mode    <= led_mode_next;
      blink_phase <= blink_phase_next;
      led_level   <= led_level_next;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (op_ready) begin
      result_valid <= op_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      result.led_levels   <= levels_next;
      result.frame_done   <= op.frame_done;
      result.frame_status <= op.status;
    end
  end

endmodule

>>> hdl/led_command_frame_blinker_unit.sv
// ----------------------------------------------------------------------------
// led_command_frame_blinker_unit: LED command frame blinker
// Parses six-byte LED command frames and drives LED levels on tick beats.
// ----------------------------------------------------------------------------
// Usage:
// - The item channel carries one beat per command byte (kind 0) or per blink
//   tick (kind 1). Every beat yields exactly one result beat, in order.
// - A result carries the LED levels after the beat, and for the sixth byte
//   of a frame frame_done with the frame status.
// - An item passes combinationally through the parser and is registered in
//   its two-entry queue, then in the driver's output register.
// - Throughput is one beat per cycle unless results stall; the queue and the
//   output register let the parser keep accepting while a result waits.
// - When the result side stalls, the queue fills and item_ready falls after
//   two further beats; nothing is dropped.
// - Reset clears the byte position, all LED modes to off, blink phases and
//   levels to zero, and empties the queue and output register. The block
//   accepts items as soon as reset is released.
// ----------------------------------------------------------------------------
module led_command_frame_blinker_unit #(
  parameter int unsigned NUM_LEDS = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_ready,
  input  lcfb_pkg::item_t   item,
  output logic              result_valid,
  input  logic              result_ready,
  output lcfb_pkg::result_t result
);

  logic          fr_valid;
  logic          fr_ready;
  lcfb_pkg::op_t fr_op;
  logic          bk_valid;
  logic          bk_ready;
  lcfb_pkg::op_t bk_op;

  // Frame parser.
  lcfb_front #(
    .NUM_LEDS(NUM_LEDS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .item_valid(item_valid),
    .item_ready(item_ready),
    .item      (item),
    .op_valid  (fr_valid),
    .op_ready  (fr_ready),
    .op        (fr_op)
  );

  // Operation queue.
  lcfb_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push_valid(fr_valid),
    .push_ready(fr_ready),
    .push_op   (fr_op),
    .pop_valid (bk_valid),
    .pop_ready (bk_ready),
    .pop_op    (bk_op)
  );

  // LED driver.
  lcfb_back #(
    .NUM_LEDS(NUM_LEDS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .op_valid    (bk_valid),
    .op_ready    (bk_ready),
    .op          (bk_op),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result      (result)
  );

  // Levels of the last delivered result, for checking.
  logic [lcfb_pkg::LEVELS_W-1:0] last_levels;

  always_ff @(posedge clk) begin
    if (rst) begin
      last_levels <= '0;
    end else if (result_valid && result_ready) begin
      last_levels <= result.led_levels;
    end
  end

  // A finished frame always reports a status, and no other beat does.
  a_status_with_done: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.frame_done == (result.frame_status != lcfb_pkg::STAT_NONE)))
    else $error("frame status does not match frame_done");

  // A frame only sets a mode; levels change on ticks alone.
  a_frame_keeps_levels: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.frame_done) |-> (result.led_levels == last_levels))
    else $error("frame result changed LED levels");

  // Levels of LEDs that do not exist stay low.
  a_absent_leds_low: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> ((result.led_levels >> NUM_LEDS) == '0))
    else $error("level driven for an absent LED");

endmodule

>>> dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench of the LED command frame blinker
// Sends command bytes and blink ticks through the item channel, predicts the
// LED levels and frame status of every beat with a model of its own, and
// checks each result beat field by field in order. The sender works in bursts
// with random gaps. The receiver stalls on a pattern that changes over time.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int unsigned LED_COUNT    = 4;
  localparam int unsigned RANDOM_BEATS = 1650;
  localparam int unsigned MAX_REPORTS  = 30;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              item_valid = 1'b0;
  logic              item_ready;
  lcfb_pkg::item_t   item = '0;
  logic              result_valid;
  logic              result_ready = 1'b0;
  lcfb_pkg::result_t result;

  led_command_frame_blinker_unit #(
    .NUM_LEDS(LED_COUNT)
  ) dut (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item_valid),
    .item_ready  (item_ready),
    .item        (item),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result      (result)
  );

  always #5 clk = ~clk;

  // Beats waiting to be sent, and results waiting to be seen.
  lcfb_pkg::item_t   command_beats[$];
  lcfb_pkg::result_t expected_led_results[$];

  // Predicted state of the block.
  int unsigned     byte_pos = 0;
  logic [7:0]      frame_buf[lcfb_pkg::STORE_LEN];
  lcfb_pkg::mode_t led_mode_q[LED_COUNT];
  logic            blink_phase_q[LED_COUNT];
  logic            level_q[LED_COUNT];

  // Run statistics.
  int unsigned mismatch_count = 0;
  int unsigned frames_applied = 0;
  int unsigned frames_malformed = 0;
  int unsigned frames_range = 0;
  int unsigned ticks_seen = 0;
  int unsigned beats_checked = 0;
  int unsigned beats_queued = 0;
  int unsigned gen_pos = 0;

  function automatic logic char_is_digit(input logic [7:0] c);
    return (c >= lcfb_pkg::CH_ZERO) && (c <= lcfb_pkg::CH_NINE);
  endfunction

  function automatic lcfb_pkg::mode_t mode_from_char(input logic [7:0] c);
    if (c == lcfb_pkg::CH_ONE) return lcfb_pkg::MODE_ON;
    if (c == lcfb_pkg::CH_TWO) return lcfb_pkg::MODE_BLINK;
    return lcfb_pkg::MODE_OFF;
  endfunction

  // Apply one accepted beat to the predicted state and return its result.
  function automatic lcfb_pkg::result_t next_led_result(input lcfb_pkg::item_t it);
    lcfb_pkg::result_t r;
    lcfb_pkg::status_t st;
    logic              led_ok;
    int                num;
    lcfb_pkg::mode_t   new_mode;
    st       = lcfb_pkg::STAT_NONE;
    led_ok   = 1'b0;
    num      = 0;
    new_mode = lcfb_pkg::MODE_OFF;
    r        = '0;
    if (it.kind == lcfb_pkg::KIND_TICK) begin
      ticks_seen++;
      for (int i = 0; i < LED_COUNT; i++) begin
        case (led_mode_q[i])
          lcfb_pkg::MODE_ON: begin
            level_q[i]    = 1'b1;
            led_mode_q[i] = lcfb_pkg::MODE_DONE;
          end
          lcfb_pkg::MODE_OFF: begin
            level_q[i]    = 1'b0;
            led_mode_q[i] = lcfb_pkg::MODE_DONE;
          end
          lcfb_pkg::MODE_BLINK: begin
            level_q[i]       = blink_phase_q[i];
            blink_phase_q[i] = ~blink_phase_q[i];
          end
          default: ;
        endcase
      end
    end else if (byte_pos < lcfb_pkg::STORE_LEN) begin
      frame_buf[byte_pos] = it.frame_byte;
      byte_pos++;
    end else begin
      // Sixth byte: decode the whole frame.
      r.frame_done = 1'b1;
      byte_pos     = 0;
      if (frame_buf[0] != lcfb_pkg::CH_HASH ||
          (frame_buf[4] != lcfb_pkg::CH_BANG && it.frame_byte != lcfb_pkg::CH_BANG)) begin
        st = lcfb_pkg::STAT_MALFORMED;
      end else if (frame_buf[2] == lcfb_pkg::CH_TILDE) begin
        if (!char_is_digit(frame_buf[1])) begin
          st = lcfb_pkg::STAT_MALFORMED;
        end else begin
          num      = int'(frame_buf[1]) - int'(lcfb_pkg::CH_ZERO);
          new_mode = mode_from_char(frame_buf[3]);
          led_ok   = 1'b1;
        end
      end else if (frame_buf[3] == lcfb_pkg::CH_TILDE) begin
        if (!char_is_digit(frame_buf[1]) || !char_is_digit(frame_buf[2])) begin
          st = lcfb_pkg::STAT_MALFORMED;
        end else begin
          num = (int'(frame_buf[1]) - int'(lcfb_pkg::CH_ZERO)) * 10 +
                (int'(frame_buf[2]) - int'(lcfb_pkg::CH_ZERO));
          new_mode = mode_from_char(frame_buf[4]);
          led_ok   = 1'b1;
        end
      end else begin
        st = lcfb_pkg::STAT_MALFORMED;
      end
      if (led_ok) begin
        if (num >= int'(LED_COUNT)) begin
          st = lcfb_pkg::STAT_RANGE;
        end else begin
          led_mode_q[num] = new_mode;
          st              = lcfb_pkg::STAT_APPLIED;
        end
      end
      case (st)
        lcfb_pkg::STAT_APPLIED:   frames_applied++;
        lcfb_pkg::STAT_MALFORMED: frames_malformed++;
        default:                  frames_range++;
      endcase
    end
    for (int i = 0; i < LED_COUNT && i < lcfb_pkg::LEVELS_W; i++) begin
      r.led_levels[i] = level_q[i];
    end
    r.frame_status = st;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) begin
      $display("[%0t] MISMATCH %s: got %0d, want %0d", $time, what, got, want);
    end
  endtask

  task automatic queue_beat(input logic kind, input logic [7:0] b);
    lcfb_pkg::item_t it;
    it.kind       = kind;
    it.frame_byte = b;
    command_beats.push_back(it);
    beats_queued++;
    if (kind == lcfb_pkg::KIND_BYTE) begin
      gen_pos = (gen_pos + 1) % lcfb_pkg::FRAME_LEN;
    end
  endtask

  // Queue the six bytes of a frame, byte 0 in the top bits, with ticks
  // scattered between them at the given percentage.
  task automatic queue_frame(input logic [47:0] f, input int unsigned tick_pct);
    for (int k = 0; k < lcfb_pkg::FRAME_LEN; k++) begin
      if ($urandom_range(0, 99) < tick_pct) begin
        queue_beat(lcfb_pkg::KIND_TICK, 8'($urandom));
      end
      queue_beat(lcfb_pkg::KIND_BYTE, f[47 - 8 * k -: 8]);
    end
  endtask

  // Driver: bursts of beats with random gaps between them.
  int unsigned burst_left = 1;
  int unsigned gap_left = 0;

  always @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
      burst_left <= $urandom_range(1, 40);
      gap_left   <= 0;
    end else begin
      if (item_valid && item_ready) begin
        expected_led_results.push_back(next_led_result(item));
      end
      if (item_valid && !item_ready) begin
        // Hold the current beat until it is taken.
      end else if (gap_left > 0) begin
        gap_left   <= gap_left - 1;
        item_valid <= 1'b0;
      end else if (command_beats.size() > 0) begin
        item       <= command_beats.pop_front();
        item_valid <= 1'b1;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 40);
          gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        item_valid <= 1'b0;
      end
    end
  end

  // Monitor: check each result beat and stall on a changing pattern.
  int unsigned       cyc = 0;
  lcfb_pkg::result_t want;

  always @(posedge clk) begin
    if (rst) begin
      result_ready <= 1'b0;
    end else begin
      cyc <= cyc + 1;
      if (result_valid && result_ready) begin
        beats_checked++;
        if (expected_led_results.size() == 0) begin
          report_mismatch("result with nothing expected", int'(result), 0);
        end else begin
          want = expected_led_results.pop_front();
          if (result.led_levels != want.led_levels)
            report_mismatch("led_levels", result.led_levels, want.led_levels);
          if (result.frame_done != want.frame_done)
            report_mismatch("frame_done", result.frame_done, want.frame_done);
          if (result.frame_status != want.frame_status)
            report_mismatch("frame_status", result.frame_status, want.frame_status);
        end
      end
      case ((cyc / 256) % 4)
        0:       result_ready <= 1'b1;
        1:       result_ready <= ($urandom_range(0, 9) > 2);
        2:       result_ready <= ((cyc % 7) >= 3);
        default: result_ready <= ((cyc % 64) >= 20);
      endcase
    end
  end

  // Stimulus and end of run.
  initial begin : stimulus
    logic [7:0]  fb[lcfb_pkg::FRAME_LEN];
    int unsigned pick;
    int unsigned num;
    int unsigned bang;
    for (int i = 0; i < LED_COUNT; i++) begin
      led_mode_q[i]    = lcfb_pkg::MODE_OFF;
      blink_phase_q[i] = 1'b0;
      level_q[i]       = 1'b0;
    end
    for (int i = 0; i < lcfb_pkg::STORE_LEN; i++) frame_buf[i] = '0;

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed: blink with the bang in byte 4, ticks that drive every mode,
    // an on command in the two-digit form, an LED number out of range and a
    // non-digit LED number.
    queue_frame({"#1~2!", 8'hFF}, 0);
    queue_beat(lcfb_pkg::KIND_TICK, 8'h00);
    queue_beat(lcfb_pkg::KIND_TICK, 8'hFF);
    queue_frame("#03~1!", 0);
    queue_beat(lcfb_pkg::KIND_TICK, 8'h5A);
    queue_frame("#12~1!", 0);
    queue_frame({"#x~1", 8'h00, "!"}, 0);

    // Let everything drain before the random part starts.
    do @(negedge clk);
    while (command_beats.size() != 0 || item_valid || expected_led_results.size() != 0);

    // Random: mostly well-formed frames with random content, some broken
    // frames, loose bytes and ticks.
    while (beats_queued < RANDOM_BEATS + 26) begin
      pick = $urandom_range(0, 99);
      if (pick < 15) begin
        queue_beat(lcfb_pkg::KIND_TICK, 8'($urandom));
      end else if (pick < 23) begin
        queue_beat(lcfb_pkg::KIND_BYTE, 8'($urandom));
      end else begin
        // Finish a frame left open by loose bytes.
        while (gen_pos != 0) queue_beat(lcfb_pkg::KIND_BYTE, 8'($urandom));
        for (int k = 0; k < lcfb_pkg::FRAME_LEN; k++) fb[k] = 8'($urandom);
        fb[0] = lcfb_pkg::CH_HASH;
        pick  = $urandom_range(0, 9);
        if ($urandom_range(0, 1) == 0) begin
          // One-digit form.
          num   = (pick < 8) ? $urandom_range(0, LED_COUNT - 1) : $urandom_range(0, 9);
          fb[1] = (pick == 9) ? 8'($urandom) : 8'(lcfb_pkg::CH_ZERO + num);
          fb[2] = lcfb_pkg::CH_TILDE;
          case ($urandom_range(0, 9))
            0, 1, 2, 3: fb[3] = lcfb_pkg::CH_ONE;
            4, 5, 6:    fb[3] = lcfb_pkg::CH_TWO;
            7, 8:       fb[3] = lcfb_pkg::CH_ZERO;
            default:    fb[3] = 8'($urandom);
          endcase
          bang = $urandom_range(0, 2);
          if (bang != 1) fb[4] = lcfb_pkg::CH_BANG;
          if (bang != 0) fb[5] = lcfb_pkg::CH_BANG;
        end else begin
          // Two-digit form.
          num   = (pick < 8) ? $urandom_range(0, LED_COUNT - 1) : $urandom_range(0, 99);
          fb[1] = 8'(lcfb_pkg::CH_ZERO + num / 10);
          fb[2] = 8'(lcfb_pkg::CH_ZERO + num % 10);
          if (pick == 9) fb[$urandom_range(1, 2)] = 8'($urandom);
          fb[3] = lcfb_pkg::CH_TILDE;
          case ($urandom_range(0, 9))
            0, 1, 2, 3: fb[4] = lcfb_pkg::CH_ONE;
            4, 5, 6:    fb[4] = lcfb_pkg::CH_TWO;
            7:          fb[4] = lcfb_pkg::CH_BANG;
            8:          fb[4] = lcfb_pkg::CH_ZERO;
            default:    fb[4] = 8'($urandom);
          endcase
          if ($urandom_range(0, 7) != 0) fb[5] = lcfb_pkg::CH_BANG;
        end
        // Now and then spoil one byte of the frame.
        if ($urandom_range(0, 9) == 0) fb[$urandom_range(0, 5)] = 8'($urandom);
        queue_frame({fb[0], fb[1], fb[2], fb[3], fb[4], fb[5]}, 8);
      end
    end

    do @(negedge clk);
    while (command_beats.size() != 0 || item_valid || expected_led_results.size() != 0);
    repeat (10) @(negedge clk);

    if (expected_led_results.size() != 0) begin
      report_mismatch("results never seen", expected_led_results.size(), 0);
    end
    $display("Checked %0d result beats: %0d ticks, %0d frames applied,",
             beats_checked, ticks_seen, frames_applied);
    $display("%0d malformed frames, %0d LED numbers out of range, %0d mismatches.",
             frames_malformed, frames_range, mismatch_count);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #4_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

>>> files.f
hdl/lcfb_pkg.sv
hdl/lcfb_front.sv
hdl/lcfb_queue.sv
hdl/lcfb_back.sv
hdl/led_command_frame_blinker_unit.sv
dv/tb_top.sv
